// ===== design/kpi_pkg.sv =====
// Shared types and constants for the keyframe path interpolator.
`timescale 1ns / 1ps
package kpi_pkg;

    localparam int NODE_W    = 8;
    localparam int MAX_NODES = 256;
    localparam int DATA_W    = 32;
    localparam int LEN_W     = 9;
    localparam int FRAC_W    = 16;
    localparam int N_LANES   = 6;
    localparam int IN_TDATA_W  = 272;
    localparam int OUT_TDATA_W = 208;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STAT_RESULT = 2'd0,
        STAT_ACK    = 2'd1,
        STAT_SHORT  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_STEP,
        S_POST,
        S_RWD,
        S_RWD2,
        S_DIVS,
        S_DIVW,
        S_LRD1,
        S_LRD2,
        S_LMUL,
        S_LSUM,
        S_HCAP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic cap_a;
        logic mul_en;
        logic sum_en;
        logic hold_cap;
    } t_lane_ctrl;

endpackage

// ===== design/kpi_lane.sv =====
// One coordinate lane: node store, linear blend multiplier and result register.
`timescale 1ns / 1ps
module kpi_lane import kpi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [NODE_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [NODE_W-1:0] i_raddr,
    input  t_lane_ctrl        i_ctrl,
    input  logic [FRAC_W:0]   i_frac,
    output logic [DATA_W-1:0] o_value
);

    logic [DATA_W-1:0]          r_mem [MAX_NODES];
    logic [DATA_W-1:0]          r_rdata;
    logic [DATA_W-1:0]          r_a;
    logic signed [DATA_W+18:0]  r_prod;
    logic [DATA_W-1:0]          r_value;
    logic signed [DATA_W:0]     diff;
    logic signed [FRAC_W+1:0]   frac_s;

    assign diff   = $signed({r_rdata[DATA_W-1], r_rdata}) - $signed({r_a[DATA_W-1], r_a});
    assign frac_s = $signed({1'b0, i_frac});

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
        if (i_ctrl.cap_a) begin
            r_a <= r_rdata;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= diff * frac_s;
        end
        // arithmetic shift by 16 floors toward minus infinity
        if (i_ctrl.sum_en) begin
            r_value <= r_a + r_prod[FRAC_W+DATA_W-1:FRAC_W];
        end else if (i_ctrl.hold_cap) begin
            r_value <= r_rdata;
        end
    end

    assign o_value = r_value;

endmodule

// ===== design/kpi_divider.sv =====
// Restoring divider for the Q1.16 blend fraction, one quotient bit per cycle.
`timescale 1ns / 1ps
module kpi_divider import kpi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [FRAC_W:0]   o_quot
);

    logic                r_busy;
    logic                r_done;
    logic [3:0]          r_cnt;
    logic [DATA_W:0]     r_rem;
    logic [DATA_W-1:0]   r_div;
    logic [FRAC_W:0]     r_quot;
    logic [DATA_W:0]     rem2;
    logic                fits;

    assign rem2 = {r_rem[DATA_W-1:0], 1'b0};
    assign fits = rem2 >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_div  <= i_divisor;
                r_rem  <= {1'b0, i_dividend};
                r_cnt  <= '0;
                // dividend equals divisor: fraction is exactly one
                if (i_dividend == i_divisor) begin
                    r_quot <= {1'b1, {FRAC_W{1'b0}}};
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_quot <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= fits ? rem2 - {1'b0, r_div} : rem2;
                r_quot <= {r_quot[FRAC_W-1:0], fits};
                r_cnt  <= r_cnt + 4'd1;
                if (r_cnt == 4'(FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== design/keyframe_path_interpolator_unit.sv =====
// Top level of the keyframe path interpolator: sequencer, segment state and output merge.
// Each item is taken alone. A node write, a no-op request or a request on a path
// shorter than two nodes goes straight to the answer; a start reads one duration; a
// held query reads the current node from the six coordinate lanes. A playback query
// walks the segments one step at a time (one duration read, one update), up to
// MAX_SEARCH steps, then starts and runs the bit-serial fraction divider (which skips
// the bit loop when the time sits at the segment end) and then the lanes and merge (two
// node reads, multiply, add, output load). The node stores come up undefined and need
// no clearing. A result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
module keyframe_path_interpolator_unit import kpi_pkg::*; #(
    parameter int MAX_SEARCH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // node_index[7:0], in_pos_x[39:8], in_pos_y[71:40], in_pos_z[103:72],
    // in_tgt_x[135:104], in_tgt_y[167:136], in_tgt_z[199:168],
    // in_duration[231:200], time_now[263:232], hold[264]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // req_type[1:0]
    input  logic [1:0]             i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // segment_index[7:0], out_pos_x[39:8], out_pos_y[71:40], out_pos_z[103:72],
    // out_tgt_x[135:104], out_tgt_y[167:136], out_tgt_z[199:168], wrapped[200]
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // status[1:0]
    output logic [1:0]             o_m_tuser,
    input  logic                   i_cfg_wr_en,
    input  logic [LEN_W-1:0]       i_cfg_wr_data
);

    localparam int SW = $clog2(MAX_SEARCH + 1);

    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_path_len;
    logic [NODE_W-1:0]   r_cs;
    logic [DATA_W-1:0]   r_seg_begin;
    logic [DATA_W-1:0]   r_seg_end;
    t_req                r_req;
    t_status             r_kind;
    logic [DATA_W-1:0]   r_time;
    logic                r_hold;
    logic                r_wrapped;
    logic [SW-1:0]       r_s;
    logic [FRAC_W:0]     r_frac;
    logic [DATA_W-1:0]   r_dur_mem [MAX_NODES];
    logic [DATA_W-1:0]   r_dur_q;

    logic                r_ovalid;
    t_status             r_o_status;
    logic [NODE_W-1:0]   r_o_seg;
    logic [DATA_W-1:0]   r_o_node [N_LANES];
    logic                r_o_wrap;

    logic                s_xfer;
    logic                load_out;
    logic [LEN_W-1:0]    eff_len;
    logic [LEN_W-1:0]    last_seg;
    logic                at_end;
    logic                short_path;
    logic [NODE_W-1:0]   dur_raddr;
    logic [NODE_W-1:0]   lane_raddr;
    t_lane_ctrl          lane_ctrl;
    logic                div_start;
    logic                div_done;
    logic [FRAC_W:0]     div_quot;
    logic [DATA_W-1:0]   seg_len;
    logic [DATA_W-1:0]   t_eff;
    logic [DATA_W-1:0]   dt_raw;
    logic [DATA_W-1:0]   dt;
    logic [DATA_W:0]     end_sum;
    logic [DATA_W-1:0]   lane_val [N_LANES];
    t_req                in_req;

    assign in_req     = t_req'(i_s_tuser);
    assign o_s_tready = (r_state == S_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign load_out   = (r_state == S_DONE) && (!r_ovalid || i_m_tready);

    assign eff_len    = (r_path_len > LEN_W'(MAX_NODES)) ? LEN_W'(MAX_NODES) : r_path_len;
    assign short_path = eff_len < LEN_W'(2);
    assign last_seg   = eff_len - LEN_W'(1);
    assign at_end     = {1'b0, r_cs} >= last_seg;

    assign end_sum = {1'b0, r_seg_end} + {1'b0, r_dur_q};
    assign seg_len = (r_seg_end - r_seg_begin == '0) ? DATA_W'(1) : r_seg_end - r_seg_begin;
    assign t_eff   = r_wrapped ? '0 : r_time;
    assign dt_raw  = (t_eff > r_seg_begin) ? t_eff - r_seg_begin : '0;
    assign dt      = (dt_raw > seg_len) ? seg_len : dt_raw;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    if (in_req == REQ_WRITE || in_req == REQ_NOP || short_path) begin
                        n_state = S_DONE;
                    end else if (in_req == REQ_START) begin
                        n_state = S_RWD;
                    end else if (i_s_tdata[264]) begin
                        n_state = S_LRD1;
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (r_s == SW'(MAX_SEARCH)) begin
                    n_state = S_POST;
                end else if (at_end) begin
                    n_state = S_RWD;
                end else if (r_time < r_seg_end) begin
                    n_state = S_POST;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP:  n_state = S_SRCH;
            S_POST:  n_state = at_end ? S_RWD : S_DIVS;
            S_RWD:   n_state = S_RWD2;
            S_RWD2:  n_state = (r_req == REQ_START) ? S_DONE : S_DIVS;
            S_DIVS:  n_state = S_DIVW;
            S_DIVW:  n_state = div_done ? S_LRD1 : S_DIVW;
            S_LRD1:  n_state = r_hold ? S_HCAP : S_LRD2;
            S_LRD2:  n_state = S_LMUL;
            S_LMUL:  n_state = S_LSUM;
            S_LSUM:  n_state = S_DONE;
            S_HCAP:  n_state = S_DONE;
            S_DONE:  n_state = load_out ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        dur_raddr  = r_cs + NODE_W'(1);
        lane_raddr = r_cs;
        lane_ctrl  = '0;
        div_start  = 1'b0;
        case (r_state)
            S_RWD:  dur_raddr = NODE_W'(1);
            S_DIVS: div_start = 1'b1;
            S_LRD2: begin
                lane_raddr      = r_cs + NODE_W'(1);
                lane_ctrl.cap_a = 1'b1;
            end
            S_LMUL: lane_ctrl.mul_en   = 1'b1;
            S_LSUM: lane_ctrl.sum_en   = 1'b1;
            S_HCAP: lane_ctrl.hold_cap = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer && in_req == REQ_WRITE) begin
            r_dur_mem[i_s_tdata[7:0]] <= i_s_tdata[231:200];
        end
        r_dur_q <= r_dur_mem[dur_raddr];
        if (s_xfer) begin
            r_time <= i_s_tdata[263:232];
            r_hold <= i_s_tdata[264];
        end
        if (div_done) begin
            r_frac <= div_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_path_len  <= LEN_W'(2);
            r_cs        <= '0;
            r_seg_begin <= '0;
            r_seg_end   <= '0;
            r_req       <= REQ_NOP;
            r_kind      <= STAT_ACK;
            r_wrapped   <= 1'b0;
            r_s         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_path_len <= i_cfg_wr_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        r_req     <= in_req;
                        r_wrapped <= 1'b0;
                        r_s       <= '0;
                        if (in_req == REQ_WRITE || in_req == REQ_NOP) begin
                            r_kind <= STAT_ACK;
                        end else if (short_path) begin
                            r_kind <= STAT_SHORT;
                        end else if (in_req == REQ_START) begin
                            r_kind <= STAT_ACK;
                        end else begin
                            r_kind <= STAT_RESULT;
                        end
                    end
                end
                S_STEP: begin
                    r_seg_begin <= r_seg_end;
                    r_seg_end   <= end_sum[DATA_W] ? '1 : end_sum[DATA_W-1:0];
                    r_cs        <= r_cs + NODE_W'(1);
                    r_s         <= r_s + SW'(1);
                end
                S_RWD: begin
                    if (r_req == REQ_QUERY) begin
                        r_wrapped <= 1'b1;
                    end
                end
                S_RWD2: begin
                    r_cs        <= '0;
                    r_seg_begin <= '0;
                    r_seg_end   <= r_dur_q;
                end
                default: ;
            endcase
        end
    end

    kpi_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dt),
        .i_divisor  (seg_len),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    for (genvar k = 0; k < N_LANES; k++) begin : g_lane
        kpi_lane u_lane (
            .i_clk   (i_clk),
            .i_we    (s_xfer && in_req == REQ_WRITE),
            .i_waddr (i_s_tdata[7:0]),
            .i_wdata (i_s_tdata[8+DATA_W*k +: DATA_W]),
            .i_raddr (lane_raddr),
            .i_ctrl  (lane_ctrl),
            .i_frac  (r_frac),
            .o_value (lane_val[k])
        );
    end

    // merge lane results and status into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_status <= r_kind;
            r_o_seg    <= r_cs;
            r_o_wrap   <= r_wrapped;
            for (int k = 0; k < N_LANES; k++) begin
                r_o_node[k] <= (r_kind == STAT_RESULT) ? lane_val[k] : '0;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_o_status;
    assign o_m_tdata  = {7'd0, r_o_wrap, r_o_node[5], r_o_node[4], r_o_node[3],
                         r_o_node[2], r_o_node[1], r_o_node[0], r_o_seg};

endmodule

// ===== design/kpi_checker.sv =====
// Port-level checks for the keyframe path interpolator, bound to the top level.
`timescale 1ns / 1ps
module kpi_checker import kpi_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic [1:0]             o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken while busy");

    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != STAT_RESULT |-> o_m_tdata[OUT_TDATA_W-1:8] == '0)
        else $error("non-query result carries node data or wrap");

    a_wrap_seg0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[200] |-> o_m_tdata[7:0] == 8'd0)
        else $error("wrapped result not at segment zero");

endmodule

bind keyframe_path_interpolator_unit kpi_checker u_kpi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
